// ===== sv/spmf_pkg.sv =====
// Shared constants, types and codes for the strict priority multilevel queue.
`timescale 1ns / 1ps
`default_nettype none
package spmf_pkg;

  localparam int MAX_LEVELS    = 8;
  localparam int LEVEL_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 4;
  localparam int LVL_OUT_W = 4;
  localparam int NL_W     = 5;
  localparam int LVL_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PTR_W    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W   = LVL_W + PTR_W;
  localparam int NUM_LEVELS_RST = 3;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [LVL_OUT_W-1:0]   level;
    logic                   deq_ok;
  } dec_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/spmf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spmf_ram #(
  parameter int ADDR_W = 7,
  parameter int WIDTH  = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/spmf_ctrl.sv =====
// Per-level head, tail and count registers with the request decision logic.
`timescale 1ns / 1ps
`default_nettype none
module spmf_ctrl
  import spmf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic              req_type,
  input  wire logic [PRIO_W-1:0] priority_req,
  input  wire logic [3:0]        num_levels,
  output dec_t                   dec,
  output mem_req_t               mem
);

  logic [PTR_W-1:0] head_r   [MAX_LEVELS];
  logic [PTR_W-1:0] head_nxt [MAX_LEVELS];
  logic [PTR_W-1:0] tail_r   [MAX_LEVELS];
  logic [PTR_W-1:0] tail_nxt [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_r    [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [MAX_LEVELS];

  logic [NL_W-1:0]  nl_lim;
  logic             prio_ok;
  logic [LVL_W-1:0] enq_q;
  logic [LVL_W-1:0] deq_q;
  logic             found;
  logic             is_deq;

  always_comb begin
    nl_lim = (32'(num_levels) > MAX_LEVELS) ? NL_W'(MAX_LEVELS) : NL_W'(num_levels);
    is_deq = (req_type == REQ_DEQ);
    prio_ok = (priority_req != '0) && (NL_W'(priority_req) <= nl_lim);
    enq_q = LVL_W'(priority_req - PRIO_W'(1));
    found = 1'b0;
    deq_q = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if ((cnt_r[i] != '0) && (NL_W'(i) < nl_lim)) begin
        found = 1'b1;
        deq_q = LVL_W'(i);
      end
    end
  end

  always_comb begin
    dec.status = ST_OK;
    dec.level  = '0;
    dec.deq_ok = 1'b0;
    mem.we     = 1'b0;
    mem.re     = 1'b0;
    mem.addr   = {enq_q, tail_r[enq_q]};
    for (int i = 0; i < MAX_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    if (is_deq) begin
      mem.addr = {deq_q, head_r[deq_q]};
      if (!found) begin
        dec.status = ST_EMPTY;
      end else begin
        dec.deq_ok = 1'b1;
        dec.level  = LVL_OUT_W'(deq_q) + LVL_OUT_W'(1);
        mem.re     = fire;
        if (fire) begin
          head_nxt[deq_q] = (head_r[deq_q] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                       : head_r[deq_q] + PTR_W'(1);
          cnt_nxt[deq_q]  = cnt_r[deq_q] - CNT_W'(1);
        end
      end
    end else if (!prio_ok) begin
      dec.status = ST_INVALID;
    end else if (cnt_r[enq_q] == CNT_W'(LEVEL_DEPTH)) begin
      dec.status = ST_FULL;
    end else begin
      mem.we = fire;
      if (fire) begin
        tail_nxt[enq_q] = (tail_r[enq_q] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                     : tail_r[enq_q] + PTR_W'(1);
        cnt_nxt[enq_q]  = cnt_r[enq_q] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_we_re_excl : assert property (@(posedge clk) disable iff (!rst_n)
    mem.we |-> !mem.re) else $error("store written and read together");
  a_mem_on_fire : assert property (@(posedge clk) disable iff (!rst_n)
    (mem.we || mem.re) |-> fire) else $error("store access without transfer");
  a_deq_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    mem.re |-> (cnt_r[deq_q] != '0)) else $error("read from empty level");
  a_enq_room : assert property (@(posedge clk) disable iff (!rst_n)
    mem.we |-> (cnt_r[enq_q] < CNT_W'(LEVEL_DEPTH))) else $error("write to full level");
`endif

endmodule
`default_nettype wire

// ===== sv/strict_priority_multi_fifo.sv =====
// A result passes the read stage (s1_res_r and the store's read data) and then the output register.
// Throughput: one request per cycle unless the output stalls; store access at most once per request.
// Output stalls back-pressure the store read stage, which in turn holds in_ready low.
// Reset (rst_n, synchronous, active low): all levels empty, num_levels = 3.
// Entry store contents are undefined after reset and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module strict_priority_multi_fifo
  import spmf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [PRIO_W-1:0]    in_priority_req,
  input  wire logic [DATA_W-1:0]    in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_status,
  output logic [DATA_W-1:0]         out_payload_out,
  output logic [LVL_OUT_W-1:0]      out_level_out,
  input  wire logic                 cfg_we,
  input  wire logic [3:0]           cfg_wdata
);

  logic [3:0]               num_levels_r;
  logic                     s1_valid_r;
  dec_t                     s1_res_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [DATA_W-1:0]        out_payload_r;
  logic [LVL_OUT_W-1:0]     out_level_r;

  logic                     fire;
  logic                     s1_adv;
  dec_t                     dec;
  mem_req_t                 mem;
  logic [PAYLOAD_WIDTH-1:0] rdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign fire     = in_valid && in_ready;

  spmf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .req_type     (in_req_type),
    .priority_req (in_priority_req),
    .num_levels   (num_levels_r),
    .dec          (dec),
    .mem          (mem)
  );

  spmf_ram #(
    .ADDR_W (ADDR_W),
    .WIDTH  (PAYLOAD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .re    (mem.re),
    .addr  (mem.addr),
    .wdata (PAYLOAD_WIDTH'(in_payload)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= 4'(NUM_LEVELS_RST);
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_levels_r <= cfg_wdata;
      end
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= dec;
    end
    if (s1_adv) begin
      out_status_r  <= s1_res_r.status;
      out_level_r   <= s1_res_r.level;
      out_payload_r <= s1_res_r.deq_ok ? DATA_W'(rdata) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload_out = out_payload_r;
  assign out_level_out   = out_level_r;

`ifndef SYNTHESIS
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("read stage lost a stalled request");
  a_no_fire_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !mem.re && !mem.we)
    else $error("store accessed while read stage stalled");
  a_level_only_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_level_r == '0))
    else $error("level reported on failed request");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for strict_priority_multi_fifo: random and directed traffic against a queue predictor.
`timescale 1ns / 1ps

import spmf_pkg::*;

typedef struct packed {
  status_t               status;
  logic [DATA_W-1:0]     data;
  logic [LVL_OUT_W-1:0]  level;
} outcome_t;

class level_fifo_model;
  logic [DATA_W-1:0] slot_data [MAX_LEVELS*LEVEL_DEPTH];
  int                rd_slot [MAX_LEVELS];
  int                wr_slot [MAX_LEVELS];
  int                fill [MAX_LEVELS];
  logic [3:0]        level_reg;
  outcome_t          awaited_results [$];
  int                errors;

  function new();
    level_reg = NUM_LEVELS_RST;
    errors = 0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      rd_slot[i] = 0;
      wr_slot[i] = 0;
      fill[i] = 0;
    end
  endfunction

  function void set_levels(logic [3:0] value);
    level_reg = value;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  function int levels_active();
    return (level_reg > MAX_LEVELS) ? MAX_LEVELS : int'(level_reg);
  endfunction

  function void note_request(req_t kind, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] word);
    outcome_t o;
    int       lv;
    int       q;
    o.status = ST_OK;
    o.data = '0;
    o.level = '0;
    lv = levels_active();
    if (kind == REQ_ENQ) begin
      if (prio == 0 || int'(prio) > lv) begin
        o.status = ST_INVALID;
      end else begin
        q = int'(prio) - 1;
        if (fill[q] >= LEVEL_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot_data[q*LEVEL_DEPTH + wr_slot[q]] = word;
          wr_slot[q] = (wr_slot[q] + 1) % LEVEL_DEPTH;
          fill[q]++;
        end
      end
    end else begin
      q = 0;
      while (q < lv && fill[q] == 0) q++;
      if (q == lv) begin
        o.status = ST_EMPTY;
      end else begin
        o.data = slot_data[q*LEVEL_DEPTH + rd_slot[q]];
        o.level = LVL_OUT_W'(q + 1);
        rd_slot[q] = (rd_slot[q] + 1) % LEVEL_DEPTH;
        fill[q]--;
      end
    end
    awaited_results.push_back(o);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 20) $display("%0t mismatch: %s", $time, what);
  endtask

  task check_result(logic [1:0] st, logic [DATA_W-1:0] word, logic [LVL_OUT_W-1:0] lvl);
    outcome_t o;
    if (awaited_results.size() == 0) begin
      report($sformatf("unexpected transfer status=%0d data=%h level=%0d", st, word, lvl));
      return;
    end
    o = awaited_results.pop_front();
    if (st !== o.status)
      report($sformatf("status %0d, want %0d", st, o.status));
    if (word !== o.data)
      report($sformatf("payload %h, want %h", word, o.data));
    if (lvl !== o.level)
      report($sformatf("level %0d, want %0d", lvl, o.level));
  endtask
endclass

module tb_top;
  localparam int STALL_LIMIT = 2000;
  localparam int PARK_CYCLES = 300;
  localparam int PHASE_ITEMS = 105;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [PRIO_W-1:0]     in_priority_req = '0;
  logic [DATA_W-1:0]     in_payload = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [DATA_W-1:0]     out_payload_out;
  logic [LVL_OUT_W-1:0]  out_level_out;
  logic                  cfg_we = 1'b0;
  logic [3:0]            cfg_wdata = '0;

  level_fifo_model sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int park_requests = 0;
  int stall_cycles = 0;

  strict_priority_multi_fifo dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_payload_out (out_payload_out),
    .out_level_out   (out_level_out),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task drive_item(req_t kind, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] word);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_priority_req <= prio;
    in_payload <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, prio, word);
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_levels(logic [3:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_levels(value);
  endtask

  task random_item(int enq_pct);
    req_t              kind;
    logic [PRIO_W-1:0] prio;
    int                lv;
    int                pick;
    lv = sb.levels_active();
    kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
    pick = $urandom_range(0, 9);
    if (pick == 0) prio = '0;
    else if (pick == 1) prio = PRIO_W'($urandom_range(0, 15));
    else prio = PRIO_W'($urandom_range(1, (lv > 0) ? lv : 1));
    drive_item(kind, prio, $urandom());
  endtask

  // result side: random stalls, plus a long park whenever one is requested
  initial begin
    int gap;
    int holds_done;
    holds_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < park_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_status, out_payload_out, out_level_out);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
    end
  end

  initial begin
    logic [3:0] phase_levels [12];
    int         enq_pct;
    phase_levels = '{4'd1, 4'd15, 4'd8, 4'd0, 4'd3, 4'd5, 4'd2, 4'd8, 4'd12, 4'd6, 4'd8, 4'd4};
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    drive_item(REQ_DEQ, 4'd0, 32'h0000_0000);
    drive_item(REQ_ENQ, 4'd0, 32'h1234_5678);
    drive_item(REQ_ENQ, 4'd4, 32'h8765_4321);
    drive_item(REQ_ENQ, 4'd15, 32'hDEAD_BEEF);
    drive_item(REQ_ENQ, 4'd3, 32'hFFFF_FFFF);
    drive_item(REQ_ENQ, 4'd2, 32'h0000_0000);
    drive_item(REQ_ENQ, 4'd1, 32'hA5A5_A5A5);
    drive_item(REQ_ENQ, 4'd3, 32'h5A5A_5A5A);
    drive_item(REQ_DEQ, 4'd15, 32'hFFFF_FFFF);
    drive_item(REQ_DEQ, 4'd0, 32'h0000_0000);
    drive_item(REQ_DEQ, 4'd9, 32'h1111_1111);
    drive_item(REQ_DEQ, 4'd1, 32'h2222_2222);
    drive_item(REQ_DEQ, 4'd7, 32'h3333_3333);
    drive_item(REQ_ENQ, 4'd3, 32'h0F0F_0F0F);
    // shrink the level count: level 3 keeps its entry but is hidden
    drain();
    write_levels(4'd1);
    drive_item(REQ_DEQ, 4'd0, 32'h0);
    drive_item(REQ_ENQ, 4'd3, 32'hCAFE_F00D);
    drive_item(REQ_ENQ, 4'd1, 32'h0000_0001);
    drive_item(REQ_DEQ, 4'd0, 32'h0);
    drive_item(REQ_DEQ, 4'd0, 32'h0);
    drain();
    write_levels(4'd3);
    drive_item(REQ_DEQ, 4'd0, 32'h0);
    drive_item(REQ_DEQ, 4'd0, 32'h0);

    for (int p = 0; p < 12; p++) begin
      drain();
      write_levels(phase_levels[p]);
      enq_pct = (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 50 : 25);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 40 && (p == 1 || p == 6)) park_requests++;
        random_item(enq_pct);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// ===== strict_priority_multi_fifo.f =====
sv/spmf_pkg.sv
sv/spmf_ram.sv
sv/spmf_ctrl.sv
sv/strict_priority_multi_fifo.sv
tb/sv/tb_top.sv
